[design/opp_pkg.sv]
`timescale 1ns / 1ps

package opp_pkg;

    // Bitmap geometry.
    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int ROW_AW   = $clog2(MAX_ROWS);
    localparam int ROW_BITS = 64;

    // Signed working width for row arithmetic (covers -64 .. 126).
    localparam int ROW_CW = 10;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_W  = 24;
    localparam int OUT_W = 104;

    localparam int CNT_W = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 1'd1;
    localparam int CFG_W = 7;
    localparam logic [CFG_W-1:0] GRID_RESET = 7'd64;

    // Operation codes.
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_DRAW  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Status codes.
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_BAD_SLOPE = 2'd1;
    localparam logic [1:0] STAT_IGNORED   = 2'd2;

endpackage

[design/opp_ram.sv]
`timescale 1ns / 1ps

module opp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/octilinear_polyline_plotter_core.sv]
`timescale 1ns / 1ps

// Polyline plotter into a one-bit bitmap held in a single-port-read,
// single-port-write RAM of MAX_ROWS rows by 64 columns.
// Input stream (s_axis): one beat per item: start a polyline, draw a segment
// to a point, or read one row. Output stream (m_axis): exactly one result beat
// per item, in order, with status, the sticky error record and row pixels.
// Configuration: grid_rows and grid_cols through a plain write port; write
// them only while no item is in flight.
// A start, an ignored or illegal draw, or op 3 passes from acceptance to
// S_FIN and then to the output register; a read passes S_READ first. A
// sloped or vertical draw walks S_DRAW pixel by pixel: it issues one row read
// per cycle for each pixel whose row lies in the bitmap and writes the merged
// row back in the cycle after. A horizontal draw is merged as a single row mask.
// The input is ready only in S_IDLE: the next beat can be accepted in the
// cycle after the result register loads, not while an item is in progress.
// Reset clears the pen, counters, error record and per-row valid bits, so the
// whole bitmap reads as zero immediately; registers return to 64 by 64.
// A new item is accepted while the previous result still waits; if the
// receiver stalls, the finished item holds until the output register frees.

module octilinear_polyline_plotter_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // tdata: op[1:0], pos_x[7:2], pos_y[13:8], read_row[19:14], zero pad
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [opp_pkg::IN_W-1:0]      i_s_axis_tdata,
    // tdata: status[1:0], error_seen[2], error_polyline[18:3],
    //        error_point[34:19], row_bits[98:35], zero pad
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [opp_pkg::OUT_W-1:0]     o_m_axis_tdata,
    input  logic                          i_cfg_we,
    input  logic [opp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [opp_pkg::CFG_W-1:0]     i_cfg_wdata
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DRAW = 4'b0010,
        S_READ = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    function automatic logic [opp_pkg::CNT_W-1:0] sat_inc(
        input logic [opp_pkg::CNT_W-1:0] v
    );
        return (v == opp_pkg::CNT_MAX) ? v : v + 1'b1;
    endfunction

    t_state r_state, n_state;

    logic [opp_pkg::CFG_W-1:0] r_grid_rows, r_grid_cols;
    logic [5:0]                r_pen_x, n_pen_x, r_pen_y, n_pen_y;
    logic                      r_err, n_err;
    logic [opp_pkg::CNT_W-1:0] r_poly, n_poly, r_point, n_point;
    logic [opp_pkg::CNT_W-1:0] r_err_poly, n_err_poly, r_err_point, n_err_point;

    // Segment walker.
    logic [5:0]                r_cur_x, n_cur_x, r_cur_y, n_cur_y;
    logic [5:0]                r_left, n_left;
    logic                      r_x_inc, n_x_inc, r_x_dec, n_x_dec;
    logic                      r_y_inc, n_y_inc, r_y_dec, n_y_dec;
    logic                      r_horiz, n_horiz;
    logic [opp_pkg::ROW_BITS-1:0] r_hmask, n_hmask;

    // Row read for a read item.
    logic                      r_rd_ok, n_rd_ok;
    logic [opp_pkg::ROW_AW-1:0] r_rd_row, n_rd_row;

    // Pending result of the current item.
    logic [1:0]                r_res_status, n_res_status;
    logic [opp_pkg::ROW_BITS-1:0] r_res_bits, n_res_bits;

    // Write-back stage.
    logic                      r_wr_en, n_wr_en;
    logic [opp_pkg::ROW_AW-1:0] r_wr_row, n_wr_row;
    logic [opp_pkg::ROW_BITS-1:0] r_wr_mask, n_wr_mask;
    logic [opp_pkg::MAX_ROWS-1:0] r_row_valid;

    // Output register.
    logic                      r_out_valid;
    logic [1:0]                r_out_status;
    logic                      r_out_error_seen;
    logic [opp_pkg::CNT_W-1:0] r_out_error_polyline, r_out_error_point;
    logic [opp_pkg::ROW_BITS-1:0] r_out_row_bits;

    logic                      accept, out_load;
    logic [1:0]                in_op;
    logic [5:0]                in_x, in_y, in_rr;
    logic signed [6:0]         dx, dy;
    logic [5:0]                ax, ay, lo_x, hi_x;
    logic                      legal;
    logic [opp_pkg::ROW_BITS-1:0] col_mask, range_mask, step_mask;
    logic signed [opp_pkg::ROW_CW-1:0] step_row;
    logic                      step_ok, in_rd_ok;

    logic                      ram_re;
    logic [opp_pkg::ROW_AW-1:0] ram_raddr;
    logic [opp_pkg::ROW_BITS-1:0] ram_rdata, ram_wdata;

    assign in_op = i_s_axis_tdata[1:0];
    assign in_x  = i_s_axis_tdata[7:2];
    assign in_y  = i_s_axis_tdata[13:8];
    assign in_rr = i_s_axis_tdata[19:14];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_load        = (r_state == S_FIN) && (!r_out_valid || i_m_axis_tready);

    always_comb begin
        for (int j = 0; j < opp_pkg::ROW_BITS; j++) begin
            col_mask[j] = (7'(j) < r_grid_cols) && (j < opp_pkg::MAX_COLS);
        end
    end

    assign dx    = $signed({1'b0, in_x}) - $signed({1'b0, r_pen_x});
    assign dy    = $signed({1'b0, in_y}) - $signed({1'b0, r_pen_y});
    assign ax    = dx[6] ? 6'(-dx) : dx[5:0];
    assign ay    = dy[6] ? 6'(-dy) : dy[5:0];
    assign legal = (dx == 7'sd0) || (dy == 7'sd0) || (ax == ay);
    assign lo_x  = dx[6] ? in_x : r_pen_x;
    assign hi_x  = dx[6] ? r_pen_x : in_x;
    assign range_mask = ({opp_pkg::ROW_BITS{1'b1}} << lo_x)
                      & ({opp_pkg::ROW_BITS{1'b1}} >> (6'd63 - hi_x));

    assign in_rd_ok = (opp_pkg::ROW_CW'(in_rr) < opp_pkg::ROW_CW'(r_grid_rows))
                   && (opp_pkg::ROW_CW'(in_rr) < opp_pkg::ROW_CW'(opp_pkg::MAX_ROWS));

    // Row of the current pen step; negative or beyond the bitmap is dropped.
    assign step_row = $signed(opp_pkg::ROW_CW'(r_grid_rows))
                    - $signed(opp_pkg::ROW_CW'(1))
                    - $signed(opp_pkg::ROW_CW'(r_cur_y));
    assign step_ok  = !step_row[opp_pkg::ROW_CW-1]
                   && (step_row < $signed(opp_pkg::ROW_CW'(opp_pkg::MAX_ROWS)));
    assign step_mask = r_horiz ? r_hmask
                     : ((opp_pkg::ROW_BITS'(1) << r_cur_x) & col_mask);

    assign ram_re    = (accept && (in_op == opp_pkg::OP_READ) && in_rd_ok)
                    || ((r_state == S_DRAW) && step_ok);
    assign ram_raddr = (r_state == S_DRAW) ? step_row[opp_pkg::ROW_AW-1:0]
                                           : opp_pkg::ROW_AW'(in_rr);
    assign ram_wdata = (r_row_valid[r_wr_row] ? ram_rdata : '0) | r_wr_mask;

    opp_ram #(
        .WIDTH(opp_pkg::ROW_BITS),
        .DEPTH(opp_pkg::MAX_ROWS)
    ) u_bitmap (
        .i_clk  (i_clk),
        .i_we   (r_wr_en),
        .i_waddr(r_wr_row),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_pen_x      = r_pen_x;
        n_pen_y      = r_pen_y;
        n_err        = r_err;
        n_poly       = r_poly;
        n_point      = r_point;
        n_err_poly   = r_err_poly;
        n_err_point  = r_err_point;
        n_cur_x      = r_cur_x;
        n_cur_y      = r_cur_y;
        n_left       = r_left;
        n_x_inc      = r_x_inc;
        n_x_dec      = r_x_dec;
        n_y_inc      = r_y_inc;
        n_y_dec      = r_y_dec;
        n_horiz      = r_horiz;
        n_hmask      = r_hmask;
        n_rd_ok      = r_rd_ok;
        n_rd_row     = r_rd_row;
        n_res_status = r_res_status;
        n_res_bits   = r_res_bits;
        n_wr_en      = (r_state == S_DRAW) && step_ok;
        n_wr_row     = step_row[opp_pkg::ROW_AW-1:0];
        n_wr_mask    = step_mask;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res_status = opp_pkg::STAT_OK;
                    n_res_bits   = '0;
                    n_state      = S_FIN;
                    case (in_op)
                        opp_pkg::OP_START: begin
                            if (r_err) begin
                                n_res_status = opp_pkg::STAT_IGNORED;
                            end else begin
                                n_pen_x = in_x;
                                n_pen_y = in_y;
                                n_poly  = sat_inc(r_poly);
                                n_point = opp_pkg::CNT_W'(1);
                            end
                        end
                        opp_pkg::OP_DRAW: begin
                            if (r_err) begin
                                n_res_status = opp_pkg::STAT_IGNORED;
                            end else begin
                                n_point = sat_inc(r_point);
                                if (legal) begin
                                    n_pen_x = in_x;
                                    n_pen_y = in_y;
                                    n_cur_x = r_pen_x;
                                    n_cur_y = r_pen_y;
                                    n_x_inc = (dx > 7'sd0);
                                    n_x_dec = dx[6];
                                    n_y_inc = (dy > 7'sd0);
                                    n_y_dec = dy[6];
                                    // A horizontal run lies in one row: one masked step.
                                    n_horiz = (dy == 7'sd0);
                                    n_hmask = range_mask & col_mask;
                                    n_left  = (dy == 7'sd0) ? 6'd0 : ay;
                                    n_state = S_DRAW;
                                end else begin
                                    n_res_status = opp_pkg::STAT_BAD_SLOPE;
                                    n_err        = 1'b1;
                                    n_err_poly   = r_poly;
                                    n_err_point  = sat_inc(r_point);
                                end
                            end
                        end
                        opp_pkg::OP_READ: begin
                            n_rd_ok  = in_rd_ok;
                            n_rd_row = opp_pkg::ROW_AW'(in_rr);
                            n_state  = S_READ;
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_DRAW: begin
                if (r_left == 6'd0) begin
                    n_state = S_FIN;
                end else begin
                    n_left = r_left - 6'd1;
                    if (r_x_inc) n_cur_x = r_cur_x + 6'd1;
                    else if (r_x_dec) n_cur_x = r_cur_x - 6'd1;
                    if (r_y_inc) n_cur_y = r_cur_y + 6'd1;
                    else if (r_y_dec) n_cur_y = r_cur_y - 6'd1;
                end
            end
            S_READ: begin
                n_res_bits = (r_rd_ok && r_row_valid[r_rd_row]) ? (ram_rdata & col_mask) : '0;
                n_state    = S_FIN;
            end
            S_FIN: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_grid_rows <= opp_pkg::GRID_RESET;
            r_grid_cols <= opp_pkg::GRID_RESET;
            r_pen_x     <= '0;
            r_pen_y     <= '0;
            r_err       <= 1'b0;
            r_poly      <= '0;
            r_point     <= '0;
            r_err_poly  <= '0;
            r_err_point <= '0;
            r_wr_en     <= 1'b0;
            r_row_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pen_x     <= n_pen_x;
            r_pen_y     <= n_pen_y;
            r_err       <= n_err;
            r_poly      <= n_poly;
            r_point     <= n_point;
            r_err_poly  <= n_err_poly;
            r_err_point <= n_err_point;
            r_wr_en     <= n_wr_en;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    opp_pkg::CFG_GRID_ROWS: r_grid_rows <= i_cfg_wdata;
                    opp_pkg::CFG_GRID_COLS: r_grid_cols <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (r_wr_en) begin
                r_row_valid[r_wr_row] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_x      <= n_cur_x;
        r_cur_y      <= n_cur_y;
        r_left       <= n_left;
        r_x_inc      <= n_x_inc;
        r_x_dec      <= n_x_dec;
        r_y_inc      <= n_y_inc;
        r_y_dec      <= n_y_dec;
        r_horiz      <= n_horiz;
        r_hmask      <= n_hmask;
        r_rd_ok      <= n_rd_ok;
        r_rd_row     <= n_rd_row;
        r_res_status <= n_res_status;
        r_res_bits   <= n_res_bits;
        r_wr_row     <= n_wr_row;
        r_wr_mask    <= n_wr_mask;
        if (out_load) begin
            r_out_status         <= r_res_status;
            r_out_error_seen     <= r_err;
            r_out_error_polyline <= r_err_poly;
            r_out_error_point    <= r_err_point;
            r_out_row_bits       <= r_res_bits;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out_row_bits, r_out_error_point,
                              r_out_error_polyline, r_out_error_seen, r_out_status};

endmodule
